### sv/pscr_pkg.sv
// Package for the PI speed controller with setpoint ramp.
// Holds field widths, register indexes, reset values and shared structs.
// No dependencies.
package pscr_pkg;

    localparam int RPM_W    = 13;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 15;
    localparam int MODE_W   = 2;
    localparam int INTEG_W  = 24;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP  = 8'd0,
        CFG_PROP_GAIN  = 8'd1,
        CFG_INTEG_GAIN = 8'd2,
        CFG_MAX_DUTY   = 8'd3
    } t_cfg_idx;

    // Bridge modes
    typedef enum logic [MODE_W-1:0] {
        MODE_BRAKE    = 2'd0,
        MODE_FORWARD  = 2'd1,
        MODE_BACKWARD = 2'd2
    } t_mode;

    localparam logic [RPM_W-1:0]  RST_RAMP_STEP  = 13'd5;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd410;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 16'd164;
    localparam logic [DUTY_W-1:0] RST_MAX_DUTY   = 15'd25600;

    // Configuration register set
    typedef struct packed {
        logic [RPM_W-1:0]  ramp_step;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [DUTY_W-1:0] max_duty;
    } t_cfg;

    // One control tick
    typedef struct packed {
        logic                 disable_request;
        logic                 enable_request;
        logic                 pulse_timeout;
        logic [RPM_W-1:0]     measured_rpm;
        logic                 direction;
        logic [RPM_W-1:0]     target_rpm;
    } t_tick;

    // One result
    typedef struct packed {
        logic [RPM_W-1:0]  ramped_setpoint;
        logic              control_active;
        logic [MODE_W-1:0] drive_mode;
        logic [DUTY_W-1:0] duty;
    } t_result;

endpackage

### sv/pscr_cfg.sv
// Configuration registers of the PI speed controller.
// Depends on pscr_pkg.
module pscr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pscr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pscr_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output pscr_pkg::t_cfg                  o_cfg
);

    pscr_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step  <= pscr_pkg::RST_RAMP_STEP;
            r_cfg.prop_gain  <= pscr_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain <= pscr_pkg::RST_INTEG_GAIN;
            r_cfg.max_duty   <= pscr_pkg::RST_MAX_DUTY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pscr_pkg::CFG_RAMP_STEP:  r_cfg.ramp_step  <= i_cfg_data[pscr_pkg::RPM_W-1:0];
                pscr_pkg::CFG_PROP_GAIN:  r_cfg.prop_gain  <= i_cfg_data;
                pscr_pkg::CFG_INTEG_GAIN: r_cfg.integ_gain <= i_cfg_data;
                pscr_pkg::CFG_MAX_DUTY:   r_cfg.max_duty   <= i_cfg_data[pscr_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### sv/pscr_core.sv
// Control law of the PI speed controller: ramp, PI sum, clamp, integrator.
// Holds the controller state; depends on pscr_pkg.
module pscr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  pscr_pkg::t_tick     i_tick,
    input  pscr_pkg::t_cfg      i_cfg,
    output pscr_pkg::t_result   o_result
);

    logic [pscr_pkg::RPM_W-1:0]    r_setpoint;
    logic signed [pscr_pkg::INTEG_W-1:0] r_integ;
    logic                          r_enabled;
    logic [pscr_pkg::MODE_W-1:0]   r_mode;

    logic [pscr_pkg::RPM_W-1:0]    n_setpoint;
    logic signed [pscr_pkg::INTEG_W-1:0] n_integ;
    logic                          n_enabled;
    logic [pscr_pkg::MODE_W-1:0]   n_mode;

    logic                          w_en;
    logic [pscr_pkg::RPM_W:0]      w_sp_sum;
    logic signed [pscr_pkg::RPM_W:0] w_err;
    logic signed [pscr_pkg::INTEG_W-1:0] w_integ_used;
    logic signed [pscr_pkg::INTEG_W-1:0] w_integ_add;
    logic signed [30:0]            w_p;
    logic signed [40:0]            w_i;
    logic signed [41:0]            w_s;
    logic signed [37:0]            w_d;
    logic [pscr_pkg::DUTY_W-1:0]   w_lim;
    logic [pscr_pkg::DUTY_W-1:0]   w_duty;
    logic signed [pscr_pkg::INTEG_W:0] w_acc;

    // Enable requests, then setpoint ramp (up by a step, down at once)
    always_comb begin
        w_en     = (r_enabled | i_tick.enable_request) & ~i_tick.disable_request;
        w_sp_sum = {1'b0, r_setpoint} + {1'b0, i_cfg.ramp_step};
        if (r_setpoint < i_tick.target_rpm) begin
            if (w_sp_sum > {1'b0, i_tick.target_rpm}) begin
                n_setpoint = i_tick.target_rpm;
            end else begin
                n_setpoint = w_sp_sum[pscr_pkg::RPM_W-1:0];
            end
        end else begin
            n_setpoint = i_tick.target_rpm;
        end
        w_err = $signed({1'b0, n_setpoint}) - $signed({1'b0, i_tick.measured_rpm});
        // integral is cleared while the setpoint differs from the command
        w_integ_used = (r_setpoint != i_tick.target_rpm) ? '0 : r_integ;
    end

    // PI sum: Q4.12 gains, duty unit 1/256 %, so floor of the sum over 16
    always_comb begin
        w_p   = w_err * $signed({1'b0, i_cfg.prop_gain});
        w_i   = w_integ_used * $signed({1'b0, i_cfg.integ_gain});
        w_s   = $signed({{11{w_p[30]}}, w_p}) + $signed({w_i[40], w_i});
        w_d   = w_s[41:4];
        w_lim = (i_cfg.max_duty > pscr_pkg::DUTY_FULL) ? pscr_pkg::DUTY_FULL
                                                       : i_cfg.max_duty;
    end

    // Duty clamp and bridge mode
    always_comb begin
        w_duty      = '0;
        n_mode      = r_mode;
        w_integ_add = w_integ_used;
        if (w_en) begin
            if (!w_d[37]) begin
                if (w_d[36:0] > {22'd0, w_lim}) begin
                    w_duty = w_lim;
                end else begin
                    w_duty = w_d[pscr_pkg::DUTY_W-1:0];
                end
                n_mode = i_tick.direction ? pscr_pkg::MODE_BACKWARD : pscr_pkg::MODE_FORWARD;
            end else begin
                n_mode = pscr_pkg::MODE_BRAKE;
            end
        end else begin
            w_integ_add = '0;
        end
    end

    // Saturating integrator and timeout shutdown
    always_comb begin
        w_acc = {w_integ_add[pscr_pkg::INTEG_W-1], w_integ_add}
              + {{(pscr_pkg::INTEG_W - pscr_pkg::RPM_W){w_err[pscr_pkg::RPM_W]}}, w_err};
        case (w_acc[pscr_pkg::INTEG_W:pscr_pkg::INTEG_W-1])
            2'b01:   n_integ = {1'b0, {(pscr_pkg::INTEG_W-1){1'b1}}};
            2'b10:   n_integ = {1'b1, {(pscr_pkg::INTEG_W-1){1'b0}}};
            default: n_integ = w_acc[pscr_pkg::INTEG_W-1:0];
        endcase
        n_enabled = w_en & ~(i_tick.pulse_timeout & (i_tick.target_rpm != '0));

        o_result.duty            = n_enabled ? w_duty : '0;
        o_result.drive_mode      = n_mode;
        o_result.control_active  = n_enabled;
        o_result.ramped_setpoint = n_setpoint;
    end

    // State update once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_integ    <= '0;
            r_enabled  <= 1'b0;
            r_mode     <= pscr_pkg::MODE_BRAKE;
        end else if (i_adv) begin
            r_setpoint <= n_setpoint;
            r_integ    <= n_integ;
            r_enabled  <= n_enabled;
            r_mode     <= n_mode;
        end
    end

endmodule

### sv/pi_speed_controller_with_ramp_unit.sv
// Top level of the PI speed controller with setpoint ramp.
// Instantiates pscr_cfg and pscr_core; depends on pscr_pkg.
//
// Each slave-side transaction is one control tick; it yields exactly one
// master-side transaction. A tick is registered on entry, evaluated against the
// controller state by combinational logic, and its result is held in an output
// register; a tick can be accepted every cycle while the output is taken. The rate
// is set by the combinational state update
// (ramp, two parallel multipliers, clamp, saturating integrator). The
// configuration port is always ready; write it only while no tick is in flight.
module pi_speed_controller_with_ramp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: target_rpm[12:0], direction[13], measured_rpm[26:14],
    //        pulse_timeout[27], enable_request[28], disable_request[29], zero[31:30]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    // tdata: duty[14:0], drive_mode[16:15], control_active[17],
    //        ramped_setpoint[30:18], zero[31]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pscr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pscr_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    pscr_pkg::t_cfg    w_cfg;
    pscr_pkg::t_tick   r_tick;
    pscr_pkg::t_result w_result;
    pscr_pkg::t_result r_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_adv;

    pscr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pscr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_tick   (r_tick),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Handshake: the tick moves on when the output register is free or drains
    assign w_adv      = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_result};

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_tick <= i_s_tdata[29:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

endmodule

### verif/pscr_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the PI speed controller with setpoint ramp: predicts the result of
// each accepted control tick and checks the block's results in order. Depends on pscr_pkg.
package pscr_tb_pkg;
    import pscr_pkg::*;

    localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO = -(longint'(1) <<< (INTEG_W - 1));

    class pscr_scoreboard;
        // register copy
        logic [RPM_W-1:0]          ramp_step;
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         integ_gain;
        logic [DUTY_W-1:0]         max_duty;
        // controller state copy
        logic [RPM_W-1:0]          setpoint;
        logic signed [INTEG_W-1:0] integ;
        logic                      enabled;
        t_mode                     mode;
        // expected results, oldest first
        t_result                   expected_q[$];
        int errors, n_ticks, n_results, n_brake, n_clamp, n_sat, n_timeout;

        function new();
            ramp_step  = RST_RAMP_STEP;
            prop_gain  = RST_PROP_GAIN;
            integ_gain = RST_INTEG_GAIN;
            max_duty   = RST_MAX_DUTY;
            setpoint   = '0;
            integ      = '0;
            enabled    = 1'b0;
            mode       = MODE_BRAKE;
            errors     = 0;
            n_ticks    = 0;
            n_results  = 0;
            n_brake    = 0;
            n_clamp    = 0;
            n_sat      = 0;
            n_timeout  = 0;
        endfunction

        // Register write as accepted by the block; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_RAMP_STEP:  ramp_step  = data[RPM_W-1:0];
                CFG_PROP_GAIN:  prop_gain  = data;
                CFG_INTEG_GAIN: integ_gain = data;
                CFG_MAX_DUTY:   max_duty   = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        // One control tick: update the state copy and queue the expected result
        function void note_tick(t_tick t);
            logic signed [RPM_W:0] err;
            longint                pi_sum;
            longint                duty_raw;
            longint                lim;
            longint                acc;
            t_result               res;
            n_ticks++;
            if (t.enable_request)
                enabled = 1'b1;
            if (t.disable_request)
                enabled = 1'b0;

            // integrator is cleared while the setpoint differs from the command
            if (setpoint != t.target_rpm)
                integ = '0;

            // ramp up by at most one step, drop at once
            if (setpoint < t.target_rpm) begin
                if ({1'b0, setpoint} + {1'b0, ramp_step} > {1'b0, t.target_rpm})
                    setpoint = t.target_rpm;
                else
                    setpoint = setpoint + ramp_step;
            end else begin
                setpoint = t.target_rpm;
            end

            err = $signed({1'b0, setpoint}) - $signed({1'b0, t.measured_rpm});
            pi_sum = longint'(err) * longint'(prop_gain)
                   + longint'(integ) * longint'(integ_gain);
            duty_raw = pi_sum >>> 4;   // floor division by 16

            res.duty = '0;
            if (enabled) begin
                if (duty_raw >= 0) begin
                    lim = (max_duty > DUTY_FULL) ? longint'(DUTY_FULL) : longint'(max_duty);
                    if (duty_raw > lim) begin
                        duty_raw = lim;
                        n_clamp++;
                    end
                    res.duty = duty_raw[DUTY_W-1:0];
                    mode = t.direction ? MODE_BACKWARD : MODE_FORWARD;
                end else begin
                    mode = MODE_BRAKE;
                    n_brake++;
                end
            end else begin
                integ = '0;
            end

            // saturating integrator
            acc = longint'(integ) + longint'(err);
            if (acc > INTEG_HI) begin
                acc = INTEG_HI;
                n_sat++;
            end
            if (acc < INTEG_LO) begin
                acc = INTEG_LO;
                n_sat++;
            end
            integ = acc[INTEG_W-1:0];

            // lost sensor with a nonzero command switches control off
            if (t.pulse_timeout && t.target_rpm != '0) begin
                if (enabled)
                    n_timeout++;
                enabled = 1'b0;
            end
            if (!enabled)
                res.duty = '0;

            res.drive_mode      = mode;
            res.control_active  = enabled;
            res.ramped_setpoint = setpoint;
            expected_q.push_back(res);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual duty=%0d mode=%0d",
                         $time, got.duty, got.drive_mode);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            match_field("duty", 32'(want.duty), 32'(got.duty));
            match_field("drive_mode", 32'(want.drive_mode), 32'(got.drive_mode));
            match_field("control_active", 32'(want.control_active), 32'(got.control_active));
            match_field("ramped_setpoint", 32'(want.ramped_setpoint),
                        32'(got.ramped_setpoint));
        endfunction
    endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for pi_speed_controller_with_ramp_unit: clock, reset, tick and register
// drivers, result-side backpressure and the transaction monitor. Depends on pscr_pkg
// and pscr_tb_pkg.
module tb_top;
    import pscr_pkg::*;
    import pscr_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 20;
    localparam int RAND_PHASES   = 3;
    localparam int PHASE_TICKS   = 40;
    localparam int SOAK_TICKS    = 1030;   // enough ticks of full error to saturate
    localparam int DROP_TICKS    = 16;
    localparam int MAX_GAP       = 8;
    localparam int LONG_GAP      = 25;
    localparam int MAX_BURST     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_MAX_DUTY) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;
    localparam logic [RPM_W-1:0]     RPM_TOP          = '1;
    localparam logic [CFG_DAT_W-1:0] DATA_ALL_ONES    = '1;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_pattern;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [31:0]           i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [31:0]           o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data  = '0;

    pscr_scoreboard sb = new();
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          n_sent      = 0;
    int          n_phases    = 0;
    t_rx_pattern rx_pattern  = RX_OPEN;
    int          rx_left     = 0;
    int          rx_tick     = 0;

    pi_speed_controller_with_ramp_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result-side ready, switching between stall patterns
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 3));
            rx_left    = $urandom_range(10, 150);
        end
        rx_left--;
        rx_tick++;
        case (rx_pattern)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= ((rx_tick % 5) != 0);
        endcase
    end

    // Monitor: ticks are noted before results are checked within one edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_tick(t_tick'(i_s_tdata[$bits(t_tick)-1:0]));
            if (o_m_tvalid && i_m_tready)
                sb.check_result(t_result'(o_m_tdata[$bits(t_result)-1:0]));
        end
    end

    // Send one tick, opening a new burst after a random gap when the last one ran out
    task automatic send_tick(input t_tick t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, MAX_BURST);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if ($urandom_range(0, 15) == 0)
                gap = LONG_GAP;
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tdata  <= 32'(t);
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    task automatic control_tick(input int target, input bit dir, input int meas,
                                input bit tmo, input bit en, input bit dis);
        t_tick t;
        t.target_rpm      = target[RPM_W-1:0];
        t.direction       = dir;
        t.measured_rpm    = meas[RPM_W-1:0];
        t.pulse_timeout   = tmo;
        t.enable_request  = en;
        t.disable_request = dis;
        send_tick(t);
    endtask

    // Stop sending and wait until every tick has produced its result
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.n_results < n_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers and one index past the end of the map
    task automatic write_config(input logic [CFG_DAT_W-1:0] ramp,
                                input logic [CFG_DAT_W-1:0] prop,
                                input logic [CFG_DAT_W-1:0] integ,
                                input logic [CFG_DAT_W-1:0] duty_lim,
                                input logic [CFG_IDX_W-1:0] junk_idx);
        logic [CFG_IDX_W-1:0] idx_list[5];
        logic [CFG_DAT_W-1:0] val_list[5];
        idx_list = '{CFG_RAMP_STEP, CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_MAX_DUTY, junk_idx};
        val_list = '{ramp, prop, integ, duty_lim, CFG_DAT_W'($urandom)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx_list[k], val_list[k]);
        end
        i_cfg_valid <= 1'b0;
        n_phases++;
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_ramp();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_DAT_W'(RPM_TOP);
            default: return CFG_DAT_W'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DATA_ALL_ONES;
            default: return CFG_DAT_W'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_duty_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CFG_DAT_W'(DUTY_FULL);
            2:       return CFG_DAT_W'($urandom_range(int'(DUTY_FULL) + 1, 32767));
            default: return CFG_DAT_W'($urandom_range(0, int'(DUTY_FULL)));
        endcase
    endfunction

    // Well-formed run: one command held for a while, speed tracking it with noise
    task automatic run_command();
        t_tick            t;
        int               len;
        int               meas;
        logic [RPM_W-1:0] cmd;
        bit               dir;
        len = $urandom_range(5, 60);
        case ($urandom_range(0, 7))
            0:       cmd = '0;
            1:       cmd = RPM_TOP;
            default: cmd = RPM_W'($urandom);
        endcase
        dir = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
            meas = int'(cmd) + int'($urandom_range(0, 600)) - 300;
            if (meas < 0)
                meas = 0;
            if (meas > int'(RPM_TOP))
                meas = int'(RPM_TOP);
            if ($urandom_range(0, 7) == 0)
                meas = int'($urandom);
            t.target_rpm      = cmd;
            t.direction       = dir;
            t.measured_rpm    = meas[RPM_W-1:0];
            t.enable_request  = (k == 0) ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 29) == 0);
            t.disable_request = ($urandom_range(0, 59) == 0);
            t.pulse_timeout   = ($urandom_range(0, 49) == 0);
            send_tick(t);
        end
    endtask

    // Noise: every field random
    task automatic run_noise();
        int          len;
        logic [31:0] raw;
        len = $urandom_range(1, 10);
        repeat (len) begin
            raw = $urandom;
            send_tick(t_tick'(raw[$bits(t_tick)-1:0]));
        end
    endtask

    initial begin
        int start;
        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        control_tick(0, 0, 0, 0, 1, 0);                  // enable with zero command
        control_tick(RPM_TOP, 0, 0, 0, 0, 0);            // ramp up one step, forward
        control_tick(RPM_TOP, 1, 0, 0, 0, 0);            // backward
        control_tick(RPM_TOP, 1, RPM_TOP, 0, 0, 0);      // negative error, brake
        control_tick(3, 0, RPM_TOP, 0, 0, 0);            // setpoint drops at once
        control_tick(3, 0, 0, 0, 1, 1);                  // both requests, disable wins
        control_tick(3, 0, 0, 0, 0, 0);                  // disabled tick
        control_tick(3, 1, 0, 0, 1, 0);                  // enable again
        control_tick(3, 1, 0, 1, 0, 0);                  // timeout with command
        control_tick(0, 0, RPM_TOP, 1, 1, 0);            // timeout with zero command
        control_tick(0, 0, 0, 0, 0, 1);

        // directed, top register values, limit above full scale, masked data bits
        wait_idle();
        write_config(DATA_ALL_ONES, DATA_ALL_ONES, DATA_ALL_ONES, DATA_ALL_ONES,
                     CFG_FIRST_UNUSED);
        control_tick(RPM_TOP, 0, 0, 0, 1, 0);
        control_tick(RPM_TOP, 1, 0, 0, 0, 0);
        control_tick(RPM_TOP, 0, RPM_TOP, 0, 0, 0);
        control_tick(0, 1, RPM_TOP, 0, 0, 0);

        // directed, all registers zero
        wait_idle();
        write_config('0, '0, '0, '0, CFG_LAST_UNUSED);
        control_tick(RPM_TOP, 0, 0, 0, 1, 0);            // zero step holds setpoint
        control_tick(RPM_TOP, 1, 0, 0, 0, 0);
        control_tick(0, 0, 0, 0, 0, 0);

        // random phases
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            write_config(pick_ramp(), pick_gain(), pick_gain(), pick_duty_limit(),
                         CFG_IDX_W'($urandom_range(int'(CFG_FIRST_UNUSED),
                                                   int'(CFG_LAST_UNUSED))));
            start = n_sent;
            while (n_sent - start < PHASE_TICKS) begin
                if ($urandom_range(0, 4) == 0)
                    run_noise();
                else
                    run_command();
            end
        end

        // integrator soak: full positive error until it saturates, then a short
        // run of full negative error after a command change
        wait_idle();
        write_config(CFG_DAT_W'(RPM_TOP), CFG_DAT_W'(RST_PROP_GAIN), CFG_DAT_W'(1),
                     CFG_DAT_W'(DUTY_FULL), CFG_FIRST_UNUSED);
        control_tick(RPM_TOP, 0, 0, 0, 1, 0);
        repeat (SOAK_TICKS) control_tick(RPM_TOP, 0, 0, 0, 0, 0);
        repeat (DROP_TICKS) control_tick(1, 1, RPM_TOP, 0, 0, 0);

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Run covered %0d ticks and %0d results over %0d register settings.",
                 sb.n_ticks, sb.n_results, n_phases + 1);
        $display("Seen: %0d braking, %0d clamped, %0d integrator saturations, %0d timeouts.",
                 sb.n_brake, sb.n_clamp, sb.n_sat, sb.n_timeout);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
